/* rtl/tofd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofd_pkg
// Shared types, widths and the arctangent table of the four-phase ToF depth
// core: the stream payloads and the CORDIC working record.
// ----------------------------------------------------------------------------
package tofd_pkg;

    // Sample and result widths
    localparam int SAMPLE_BITS = 12;
    localparam int DIFF_BITS   = SAMPLE_BITS + 3;   // I and Q, signed
    localparam int CONF_BITS   = SAMPLE_BITS + 2;
    localparam int PHASE_BITS  = 16;
    localparam int DEPTH_BITS  = 20;
    localparam int RANGE_BITS  = 16;
    localparam int ACC_BITS    = 32;                // angle in 2^-32 turn
    localparam int PRESCALE    = 24;                // I/Q scaled by 2^24
    // Room for the CORDIC gain (~1.65) and the vector length (~sqrt 2)
    localparam int WORK_BITS   = DIFF_BITS + PRESCALE + 2;
    localparam int TABLE_LEN   = 24;
    localparam int DEPTH_SHIFT = 12;

    localparam int ANGLE_STEPS_DEFAULT = 16;
    localparam logic [RANGE_BITS-1:0] RANGE_RESET = RANGE_BITS'(1500);
    localparam logic [ACC_BITS-1:0]   HALF_TURN   = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic [ACC_BITS-1:0]   ROUND_HALF  = ACC_BITS'(32'h0000_8000);

    // Input transaction: tap A and tap B samples of the four phases
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] a_phase0;
        logic [SAMPLE_BITS-1:0] a_phase1;
        logic [SAMPLE_BITS-1:0] a_phase2;
        logic [SAMPLE_BITS-1:0] a_phase3;
        logic [SAMPLE_BITS-1:0] b_phase0;
        logic [SAMPLE_BITS-1:0] b_phase1;
        logic [SAMPLE_BITS-1:0] b_phase2;
        logic [SAMPLE_BITS-1:0] b_phase3;
    } tofd_in_t;

    // Result transaction
    typedef struct packed {
        logic [CONF_BITS-1:0]  confidence;
        logic [PHASE_BITS-1:0] phase_turns;
        logic [DEPTH_BITS-1:0] depth_q4;
    } tofd_out_t;

    // Record carried down the CORDIC pipeline
    typedef struct packed {
        logic signed [WORK_BITS-1:0] x;
        logic signed [WORK_BITS-1:0] y;
        logic [ACC_BITS-1:0]         acc;
        logic [CONF_BITS-1:0]        conf;
        logic                        zero;   // I = Q = 0, angle forced to 0
    } tofd_cordic_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [ACC_BITS-1:0] atan_turn(input int unsigned idx);
        logic [ACC_BITS-1:0] val;
        case (idx)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/tofd_cordic_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofd_cordic_stage
// One registered vectoring CORDIC iteration with its own valid/ready stage.
// ----------------------------------------------------------------------------
module tofd_cordic_stage
    import tofd_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  tofd_cordic_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output tofd_cordic_t out_data
);

    localparam logic [ACC_BITS-1:0] ATAN = atan_turn(STEP);

    logic                        valid_reg;
    tofd_cordic_t                data_reg;
    tofd_cordic_t                data_next;
    logic signed [WORK_BITS-1:0] x_in;
    logic signed [WORK_BITS-1:0] y_in;
    logic signed [WORK_BITS-1:0] xs;
    logic signed [WORK_BITS-1:0] ys;

    // Rotate toward the x axis; arithmetic shifts floor toward minus infinity
    always_comb begin
        x_in      = in_data.x;
        y_in      = in_data.y;
        xs        = x_in >>> STEP;
        ys        = y_in >>> STEP;
        data_next = in_data;
        if (!y_in[WORK_BITS-1]) begin
            data_next.x   = x_in + ys;
            data_next.y   = y_in - xs;
            data_next.acc = in_data.acc + ATAN;
        end else begin
            data_next.x   = x_in - ys;
            data_next.y   = y_in + xs;
            data_next.acc = in_data.acc - ATAN;
        end
    end

    // Stage advances when empty or when downstream takes its transaction
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/tof_four_phase_depth_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_four_phase_depth_core
// Four-phase indirect time-of-flight depth: confidence, phase and depth.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one pixel per transaction: tap A and tap B
//   samples of the 0, 90, 180 and 270 degree phases. m_valid/m_ready/m_data
//   return one result per pixel: confidence |I|+|Q|, phase in 2^-16 turn and
//   depth in 1/16 mm. cfg_we/cfg_wdata write the unambiguous range in mm;
//   write it only while the core holds no pixel.
// Timing:
//   Pipeline: an input register for I/Q, a pre-rotation stage, one register
//   per CORDIC iteration, a rounding stage and the depth multiplier at the
//   output. One pixel per cycle is accepted and delivered while m_ready is
//   high; the unrolled CORDIC chain sets the depth, the 16x16 depth
//   multiply sets the output stage.
// Reset:
//   aresetn (synchronous, active low) empties every stage and sets the
//   range to 1500 mm.
// Stall:
//   Each stage holds while its successor is full and stalled; empty stages
//   still fill, so s_ready stays high until the whole pipeline is full.
// ----------------------------------------------------------------------------
module tof_four_phase_depth_core
    import tofd_pkg::*;
#(
    parameter int ANGLE_STEPS = ANGLE_STEPS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tofd_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tofd_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [RANGE_BITS-1:0] cfg_wdata
);

    localparam int NUM_ITER = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;

    // ------------------------------------------------------------------
    // Range register
    // ------------------------------------------------------------------
    logic [RANGE_BITS-1:0] range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
        end else if (cfg_we) begin
            range_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: phase differences, I and Q
    // ------------------------------------------------------------------
    logic                        s1_valid_reg;
    logic                        s1_ready;
    logic signed [DIFF_BITS-1:0] i_reg;
    logic signed [DIFF_BITS-1:0] q_reg;
    logic signed [DIFF_BITS-1:0] i_next;
    logic signed [DIFF_BITS-1:0] q_next;
    logic signed [DIFF_BITS-1:0] ph0;
    logic signed [DIFF_BITS-1:0] ph1;
    logic signed [DIFF_BITS-1:0] ph2;
    logic signed [DIFF_BITS-1:0] ph3;
    logic                        s2_ready;

    always_comb begin
        ph0    = $signed({3'b000, s_data.a_phase0}) - $signed({3'b000, s_data.b_phase0});
        ph1    = $signed({3'b000, s_data.a_phase1}) - $signed({3'b000, s_data.b_phase1});
        ph2    = $signed({3'b000, s_data.a_phase2}) - $signed({3'b000, s_data.b_phase2});
        ph3    = $signed({3'b000, s_data.a_phase3}) - $signed({3'b000, s_data.b_phase3});
        i_next = ph0 - ph2;
        q_next = ph3 - ph1;
    end

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s_valid) begin
            i_reg <= i_next;
            q_reg <= q_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: confidence, zero check, prescale and left-half pre-rotation
    // ------------------------------------------------------------------
    logic                        s2_valid_reg;
    tofd_cordic_t                s2_reg;
    tofd_cordic_t                s2_next;
    logic [DIFF_BITS-1:0]        abs_i;
    logic [DIFF_BITS-1:0]        abs_q;
    logic [DIFF_BITS-1:0]        conf_sum;
    logic signed [WORK_BITS-1:0] x_pre;
    logic signed [WORK_BITS-1:0] y_pre;

    tofd_cordic_t stage_data  [0:NUM_ITER];
    logic         stage_valid [0:NUM_ITER];
    logic         stage_ready [0:NUM_ITER];

    always_comb begin
        abs_i    = i_reg[DIFF_BITS-1] ? DIFF_BITS'(-i_reg) : DIFF_BITS'(i_reg);
        abs_q    = q_reg[DIFF_BITS-1] ? DIFF_BITS'(-q_reg) : DIFF_BITS'(q_reg);
        conf_sum = abs_i + abs_q;
        x_pre    = WORK_BITS'(i_reg) <<< PRESCALE;
        y_pre    = WORK_BITS'(q_reg) <<< PRESCALE;
        s2_next.conf = conf_sum[CONF_BITS-1:0];
        s2_next.zero = (i_reg == '0) && (q_reg == '0);
        if (i_reg[DIFF_BITS-1]) begin
            s2_next.x   = -x_pre;
            s2_next.y   = -y_pre;
            s2_next.acc = HALF_TURN;
        end else begin
            s2_next.x   = x_pre;
            s2_next.y   = y_pre;
            s2_next.acc = '0;
        end
    end

    assign s2_ready = !s2_valid_reg || stage_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    assign stage_data[0]  = s2_reg;
    assign stage_valid[0] = s2_valid_reg;

    // ------------------------------------------------------------------
    // CORDIC iterations, one register stage each
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
        tofd_cordic_stage #(
            .STEP (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Rounding stage: nearest 2^-16 turn, wraps at a full turn
    // ------------------------------------------------------------------
    logic                  rnd_valid_reg;
    logic                  rnd_ready;
    logic [CONF_BITS-1:0]  rnd_conf_reg;
    logic [PHASE_BITS-1:0] rnd_turns_reg;
    logic [PHASE_BITS-1:0] rnd_turns_next;
    logic [ACC_BITS-1:0]   acc_rounded;
    logic                  out_ready;
    tofd_cordic_t          last;

    always_comb begin
        last           = stage_data[NUM_ITER];
        acc_rounded    = last.acc + ROUND_HALF;
        rnd_turns_next = last.zero ? '0 : acc_rounded[ACC_BITS-1 -: PHASE_BITS];
    end

    assign rnd_ready             = !rnd_valid_reg || out_ready;
    assign stage_ready[NUM_ITER] = rnd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (rnd_ready) begin
            rnd_valid_reg <= stage_valid[NUM_ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_ready && stage_valid[NUM_ITER]) begin
            rnd_conf_reg  <= last.conf;
            rnd_turns_reg <= rnd_turns_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: depth = turns * range >> 12
    // ------------------------------------------------------------------
    logic                             out_valid_reg;
    tofd_out_t                        out_reg;
    tofd_out_t                        out_next;
    logic [PHASE_BITS+RANGE_BITS-1:0] depth_prod;

    always_comb begin
        depth_prod           = rnd_turns_reg * range_reg;
        out_next.confidence  = rnd_conf_reg;
        out_next.phase_turns = rnd_turns_reg;
        out_next.depth_q4    = depth_prod[DEPTH_SHIFT +: DEPTH_BITS];
    end

    assign out_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && rnd_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-phase ToF depth core: a queue-fed pixel
// driver with bursty traffic, a result monitor with a stalling receiver and
// a long hold-off, and a bit-exact CORDIC predictor run for several ranges.
// ----------------------------------------------------------------------------
module tb_top;
    import tofd_pkg::*;

    localparam int ANGLE_STEPS = ANGLE_STEPS_DEFAULT;
    localparam int LATENCY     = ANGLE_STEPS + 4;
    localparam int DRAIN_WAIT  = 2 * LATENCY + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_MAX    = 10;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_LEN    = 150;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    tofd_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    tofd_out_t             m_data;
    logic                  cfg_we    = 1'b0;
    logic [RANGE_BITS-1:0] cfg_wdata = '0;

    tofd_in_t              pixel_q[$];      // pixels waiting to be driven
    tofd_out_t             result_q[$];     // predicted results, oldest first
    logic [RANGE_BITS-1:0] range_mm_q = RANGE_RESET;
    int                    err_cnt    = 0;
    int                    rx_cnt     = 0;
    int                    cycle_cnt  = 0;

    // atan(2^-i) in 2^-32 turn
    logic [ACC_BITS-1:0] atan_lut [0:TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    tof_four_phase_depth_core #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Expected confidence, phase and depth of one pixel
    function automatic tofd_out_t depth_predict(tofd_in_t px, logic [RANGE_BITS-1:0] rng);
        int                  ph0, ph1, ph2, ph3;
        int                  ii, qq;
        longint              x, y, xs, ys;
        logic [ACC_BITS-1:0] acc;
        logic [31:0]         prod;
        tofd_out_t           res;
        ph0 = int'(px.a_phase0) - int'(px.b_phase0);
        ph1 = int'(px.a_phase1) - int'(px.b_phase1);
        ph2 = int'(px.a_phase2) - int'(px.b_phase2);
        ph3 = int'(px.a_phase3) - int'(px.b_phase3);
        ii  = ph0 - ph2;
        qq  = ph3 - ph1;
        res.confidence = CONF_BITS'((ii < 0 ? -ii : ii) + (qq < 0 ? -qq : qq));

        // Vectoring CORDIC, left half-plane folded over by a half turn
        acc = '0;
        if (ii != 0 || qq != 0) begin
            x = longint'(ii) * 64'sd16777216;
            y = longint'(qq) * 64'sd16777216;
            if (x < 0) begin
                x   = -x;
                y   = -y;
                acc = HALF_TURN;
            end
            for (int i = 0; i < ANGLE_STEPS && i < TABLE_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x   = x + ys;
                    y   = y - xs;
                    acc = acc + atan_lut[i];
                end else begin
                    x   = x - ys;
                    y   = y + xs;
                    acc = acc - atan_lut[i];
                end
            end
            acc = acc + ROUND_HALF;
        end
        res.phase_turns = acc[31:16];
        prod            = {16'd0, res.phase_turns} * {16'd0, rng};
        res.depth_q4    = prod[31:DEPTH_SHIFT];
        return res;
    endfunction

    // Pixel whose samples give the requested I and Q
    function automatic tofd_in_t pixel_from_iq(int ii, int qq);
        tofd_in_t px;
        px = '0;
        if (ii > 0) begin
            px.a_phase0 = SAMPLE_BITS'(ii > 4095 ? 4095 : ii);
            px.b_phase2 = SAMPLE_BITS'(ii - int'(px.a_phase0));
        end else if (ii < 0) begin
            px.a_phase2 = SAMPLE_BITS'(-ii > 4095 ? 4095 : -ii);
            px.b_phase0 = SAMPLE_BITS'(-ii - int'(px.a_phase2));
        end
        if (qq > 0) begin
            px.a_phase3 = SAMPLE_BITS'(qq > 4095 ? 4095 : qq);
            px.b_phase1 = SAMPLE_BITS'(qq - int'(px.a_phase3));
        end else if (qq < 0) begin
            px.a_phase1 = SAMPLE_BITS'(-qq > 4095 ? 4095 : -qq);
            px.b_phase3 = SAMPLE_BITS'(-qq - int'(px.a_phase1));
        end
        return px;
    endfunction

    // Random pixel: mostly raw samples, some near the origin or near the axes
    function automatic tofd_in_t random_pixel();
        int sel;
        int ii, qq;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return tofd_in_t'({$urandom(), $urandom(), $urandom()});
        end else if (sel < 8) begin
            ii = $urandom_range(0, 64) - 32;
            qq = $urandom_range(0, 64) - 32;
            return pixel_from_iq(ii, qq);
        end else begin
            ii = ($urandom_range(0, 1) != 0) ? 8190 - $urandom_range(0, 3)
                                             : $urandom_range(0, 6) - 3;
            qq = $urandom_range(0, 8) - 4;
            if ($urandom_range(0, 1) != 0) ii = -ii;
            if ($urandom_range(0, 1) != 0) begin
                return pixel_from_iq(qq, ii);
            end
            return pixel_from_iq(ii, qq);
        end
    endfunction

    // Driver: bursts of transactions with random gaps, prediction on accept
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                result_q.push_back(depth_predict(s_data, range_mm_q));
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once traffic is under way
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic hold_on   = 1'b0;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (!hold_done && rx_cnt >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done <= 1'b1;
        end
        hold_on <= (hold_left != 0);
    end

    // Receiver stall pattern in one of four modes, with the mode redrawn at random
    int rx_mode  = 0;
    int rx_phase = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_phase++;
            if (rx_phase % 64 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            if (hold_on) begin
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) != 0);
                    2: m_ready <= (rx_phase % 4 != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        tofd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            rx_cnt++;
            if (result_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= SHOW_MAX) begin
                    $display("unexpected result: conf %0d phase %0d depth %0d",
                             m_data.confidence, m_data.phase_turns, m_data.depth_q4);
                end
            end else begin
                want = result_q.pop_front();
                if (m_data.confidence  !== want.confidence ||
                    m_data.phase_turns !== want.phase_turns ||
                    m_data.depth_q4    !== want.depth_q4) begin
                    err_cnt++;
                    if (err_cnt <= SHOW_MAX) begin
                        $display("mismatch #%0d: exp conf %0d phase %0d depth %0d, got conf %0d phase %0d depth %0d",
                                 rx_cnt, want.confidence, want.phase_turns, want.depth_q4,
                                 m_data.confidence, m_data.phase_turns, m_data.depth_q4);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[tof_four_phase_depth_core] ERROR");
            $finish;
        end
    end

    // Wait until every pixel is through and the pipeline has settled
    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_valid || result_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Range register write while the core is idle
    task automatic set_range(input logic [RANGE_BITS-1:0] rng);
        wait_drained();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rng;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        range_mm_q  = rng;
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            pixel_q.push_back(random_pixel());
        end
    endtask

    // Stimulus sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset range
        queue_random(150);

        // Full-scale range with the directed corners
        set_range(16'hFFFF);
        pixel_q.push_back('0);                         // zero vector
        pixel_q.push_back('1);                         // all taps saturated, zero vector
        pixel_q.push_back(tofd_in_t'({8{12'hAAA}}));
        pixel_q.push_back(tofd_in_t'({8{12'h555}}));
        pixel_q.push_back(tofd_in_t'({{4{12'hFFF}}, {4{12'h000}}}));
        pixel_q.push_back(tofd_in_t'({{4{12'h000}}, {4{12'hFFF}}}));
        pixel_q.push_back(pixel_from_iq(8190, 0));
        pixel_q.push_back(pixel_from_iq(-8190, 0));    // half turn
        pixel_q.push_back(pixel_from_iq(0, 8190));
        pixel_q.push_back(pixel_from_iq(0, -8190));
        pixel_q.push_back(pixel_from_iq(8190, 8190));
        pixel_q.push_back(pixel_from_iq(-8190, 8190));
        pixel_q.push_back(pixel_from_iq(-8190, -8190));
        pixel_q.push_back(pixel_from_iq(8190, -8190));
        pixel_q.push_back(pixel_from_iq(8190, -1));    // just below a full turn
        pixel_q.push_back(pixel_from_iq(4095, -1));
        pixel_q.push_back(pixel_from_iq(-8190, -1));
        pixel_q.push_back(pixel_from_iq(-1, 0));
        pixel_q.push_back(pixel_from_iq(1, 0));
        pixel_q.push_back(pixel_from_iq(0, 1));
        pixel_q.push_back(pixel_from_iq(0, -1));
        pixel_q.push_back(pixel_from_iq(1, -8190));
        queue_random(150);

        // Smallest non-zero range
        set_range(16'd1);
        queue_random(150);

        // Zero range, depth must read zero
        set_range(16'd0);
        queue_random(50);

        // A few random ranges
        for (int p = 0; p < 3; p++) begin
            set_range(RANGE_BITS'($urandom_range(1, 65535)));
            queue_random(100);
        end

        wait_drained();
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("[tof_four_phase_depth_core] OK");
        end else begin
            $display("[tof_four_phase_depth_core] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/tofd_pkg.sv
rtl/tofd_cordic_stage.sv
rtl/tof_four_phase_depth_core.sv
verif/tb_top.sv
